### rtl/core/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros.svh
// Assertion macros used by the ancestor engine.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// checked property, switched off while reset is high
`define BLA_ASSERT(label, clk, rst, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error(msg);

// checked property, also watched during reset
`define BLA_ASSERT_NR(label, clk, prop, msg) \
  label: assert property (@(posedge clk) prop) \
    else $error(msg);

`endif

### rtl/core/bla_pkg.sv
// ----------------------------------------------------------------------------
// bla_pkg
// Types and constants of the binary lifting ancestor engine.
// ----------------------------------------------------------------------------
package bla_pkg;

  localparam int NODE_W = 10;
  localparam int STEP_W = 10;
  localparam int DIST_W = 11;
  localparam int MODE_W = 2;
  localparam int ALU_W  = 11;

  typedef logic [NODE_W-1:0] node_t;
  typedef logic [NODE_W-1:0] level_t;
  typedef logic [STEP_W-1:0] step_t;
  typedef logic [DIST_W-1:0] dist_t;
  typedef logic [ALU_W-1:0]  alu_word_t;

  // item modes
  typedef enum logic [MODE_W-1:0] {
    MODE_ADD  = 2'd0,
    MODE_KTH  = 2'd1,
    MODE_LCA  = 2'd2,
    MODE_DIST = 2'd3
  } mode_t;

  // one ancestor table entry: present flag and ancestor node
  typedef struct packed {
    logic  ok;
    node_t id;
  } anc_ent_t;

  // per node record: loaded flag and depth
  typedef struct packed {
    logic   loaded;
    level_t level;
  } info_t;

  typedef enum logic {
    ALU_ADD = 1'b0,
    ALU_SUB = 1'b1
  } alu_op_t;

  typedef struct packed {
    alu_op_t   op;
    alu_word_t a;
    alu_word_t b;
  } alu_req_t;

  typedef struct packed {
    alu_word_t res;
    logic      borrow;
  } alu_rsp_t;

endpackage

### rtl/core/bla_req_if.sv
// ----------------------------------------------------------------------------
// bla_req_if
// Request channel: one add or query item with valid/ready handshake.
// ----------------------------------------------------------------------------
interface bla_req_if import bla_pkg::*; ();

  logic                valid;
  logic                ready;
  logic [MODE_W-1:0]   mode;
  node_t               node_a;
  node_t               node_b;
  logic                has_parent;
  step_t               steps;

  modport source (
    output valid, mode, node_a, node_b, has_parent, steps,
    input  ready
  );

  modport sink (
    input  valid, mode, node_a, node_b, has_parent, steps,
    output ready
  );

endinterface

### rtl/core/bla_rsp_if.sv
// ----------------------------------------------------------------------------
// bla_rsp_if
// Result channel: one answer item with valid/ready handshake.
// ----------------------------------------------------------------------------
interface bla_rsp_if import bla_pkg::*; ();

  logic  valid;
  logic  ready;
  node_t answer_node;
  logic  answer_valid;
  dist_t edge_count;

  modport source (
    output valid, answer_node, answer_valid, edge_count,
    input  ready
  );

  modport sink (
    input  valid, answer_node, answer_valid, edge_count,
    output ready
  );

endinterface

### rtl/core/binary_lifting_ancestor_engine.sv
// ----------------------------------------------------------------------------
// binary_lifting_ancestor_engine
// Forest of nodes kept as a table of 2^j ancestors, with add, k-th ancestor,
// lowest common ancestor and distance queries.
// ----------------------------------------------------------------------------
// After reset the engine runs a clearing pass over all NODES node records,
// and takes no item until it is done. Items are then handled one at a time;
// every item gives one result. All work goes through one read port of the
// ancestor table, so the run time follows the number of table reads: an add
// reads the parent's row level by level, a k-th ancestor query reads once per
// set bit of steps, a common ancestor query reads once per set bit of the
// depth difference and then walks every level from the top down, and a
// distance query adds an add and a subtract of the depths. A new item is taken
// once the previous result sits in the output register, even if not yet taken.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module binary_lifting_ancestor_engine import bla_pkg::*; #(
  parameter int NODES  = 1024,
  parameter int LEVELS = 10
) (
  input  logic      clk,
  input  logic      rst,
  bla_req_if.sink   req,
  bla_rsp_if.source rsp
);

  localparam int IW        = (NODES > 1) ? $clog2(NODES) : 1;
  localparam int LW        = (LEVELS > 1) ? $clog2(LEVELS) : 1;
  localparam int CW        = ((IW > NODE_W) ? IW : NODE_W) + 1;
  localparam int KW        = (LEVELS > STEP_W) ? LEVELS : STEP_W;
  localparam int TBL_DEPTH = NODES << LW;
  localparam int LIM_RAW   = (1 << LEVELS) - 1;
  localparam int DEPTH_LIM = (LIM_RAW < 1023) ? LIM_RAW : 1023;

  typedef logic [IW-1:0]    idx_t;
  typedef logic [LW-1:0]    lev_t;
  typedef logic [IW+LW-1:0] tbl_addr_t;
  typedef logic [KW-1:0]    kcnt_t;

  localparam lev_t      LAST_LEV = lev_t'(LEVELS - 1);
  localparam alu_word_t LIM_M1   = alu_word_t'(DEPTH_LIM - 1);

  typedef enum logic [23:0] {
    S_CLEAR     = 24'h000001,
    S_IDLE      = 24'h000002,
    S_RD_A      = 24'h000004,
    S_CHK_A     = 24'h000008,
    S_CHK_B     = 24'h000010,
    S_ADD_LV    = 24'h000020,
    S_ADD_W0    = 24'h000040,
    S_ADD_RD    = 24'h000080,
    S_ADD_WR    = 24'h000100,
    S_ADD_INFO  = 24'h000200,
    S_ORDER     = 24'h000400,
    S_ORDER2    = 24'h000800,
    S_CLIMB     = 24'h001000,
    S_CLIMB_WT  = 24'h002000,
    S_CLIMB_END = 24'h004000,
    S_CMP       = 24'h008000,
    S_LCA_RA    = 24'h010000,
    S_LCA_RB    = 24'h020000,
    S_LCA_UP    = 24'h040000,
    S_LCA_PR    = 24'h080000,
    S_LCA_FIN   = 24'h100000,
    S_DIST_RD   = 24'h200000,
    S_DIST_SUB  = 24'h400000,
    S_DONE      = 24'h800000
  } state_t;

  function automatic logic in_range(node_t n);
    return CW'(n) < CW'(NODES);
  endfunction

  function automatic idx_t to_idx(node_t n);
    return IW'(CW'(n));
  endfunction

  state_t   state;
  mode_t    mode_r;
  node_t    a_r;
  node_t    b_r;
  logic     hasp_r;
  kcnt_t    k_r;
  node_t    x_r;
  node_t    y_r;
  lev_t     j_r;
  anc_ent_t cur_r;
  anc_ent_t ea_r;
  level_t   la_r;
  level_t   lb_r;
  dist_t    sum_r;
  idx_t     clr_cnt;

  logic     res_ok;
  node_t    res_node;
  dist_t    res_dist;

  logic     out_full;
  node_t    out_node;
  logic     out_ok;
  dist_t    out_dist;

  // memories
  anc_ent_t  anc_mem [TBL_DEPTH];
  info_t     info_mem [NODES];
  anc_ent_t  anc_q;
  info_t     info_q;

  tbl_addr_t anc_raddr;
  tbl_addr_t anc_waddr;
  logic      anc_we;
  anc_ent_t  anc_wdata;
  idx_t      info_raddr;
  idx_t      info_waddr;
  logic      info_we;
  info_t     info_wdata;

  alu_req_t  alu_req;
  alu_rsp_t  alu_rsp;

  logic      a_ok;
  logic      b_ok;
  logic      out_load;

  bla_alu u_alu (
    .req (alu_req),
    .rsp (alu_rsp)
  );

  assign a_ok     = in_range(a_r) && info_q.loaded;
  assign b_ok     = in_range(b_r) && info_q.loaded;
  assign out_load = (state == S_DONE) && (!out_full || rsp.ready);

  assign req.ready        = (state == S_IDLE);
  assign rsp.valid        = out_full;
  assign rsp.answer_node  = out_node;
  assign rsp.answer_valid = out_ok;
  assign rsp.edge_count   = out_dist;

  // ancestor table: one write, one registered read
  always_ff @(posedge clk) begin
    if (anc_we) begin
      anc_mem[anc_waddr] <= anc_wdata;
    end
    anc_q <= anc_mem[anc_raddr];
  end

  // node records: one write, one registered read
  always_ff @(posedge clk) begin
    if (info_we) begin
      info_mem[info_waddr] <= info_wdata;
    end
    info_q <= info_mem[info_raddr];
  end

  // memory addresses and shared unit operands per step
  always_comb begin
    anc_raddr         = {to_idx(x_r), j_r};
    anc_waddr         = {to_idx(a_r), j_r};
    anc_we            = 1'b0;
    anc_wdata         = cur_r;
    info_raddr        = to_idx(a_r);
    info_waddr        = to_idx(a_r);
    info_we           = 1'b0;
    info_wdata.loaded = 1'b1;
    info_wdata.level  = la_r;
    alu_req.op        = ALU_ADD;
    alu_req.a         = '0;
    alu_req.b         = '0;
    case (state)
      S_CLEAR: begin
        info_we    = 1'b1;
        info_waddr = clr_cnt;
        info_wdata = '0;
      end
      S_CHK_A: begin
        info_raddr = to_idx(b_r);
        alu_req.op = ALU_SUB;
        alu_req.a  = alu_word_t'(info_q.level);
        alu_req.b  = alu_word_t'(k_r[STEP_W-1:0]);
      end
      S_CHK_B: begin
        alu_req.op = ALU_SUB;
        alu_req.a  = LIM_M1;
        alu_req.b  = alu_word_t'(info_q.level);
      end
      S_ADD_LV: begin
        alu_req.a = alu_word_t'(lb_r);
        alu_req.b = alu_word_t'(1);
      end
      S_ADD_W0: begin
        anc_we    = 1'b1;
        anc_waddr = {to_idx(a_r), lev_t'(0)};
      end
      S_ADD_RD: begin
        anc_raddr = {to_idx(cur_r.id), j_r - lev_t'(1)};
        if (!cur_r.ok) begin
          anc_we    = 1'b1;
          anc_wdata = '0;
        end
      end
      S_ADD_WR: begin
        anc_we    = 1'b1;
        anc_wdata = anc_q;
      end
      S_ADD_INFO: begin
        info_we = 1'b1;
      end
      S_ORDER: begin
        alu_req.op = ALU_SUB;
        alu_req.a  = alu_word_t'(la_r);
        alu_req.b  = alu_word_t'(lb_r);
      end
      S_ORDER2: begin
        alu_req.op = ALU_SUB;
        alu_req.a  = alu_word_t'(lb_r);
        alu_req.b  = alu_word_t'(la_r);
      end
      S_LCA_RB: begin
        anc_raddr = {to_idx(y_r), j_r};
      end
      S_LCA_PR: begin
        anc_raddr = {to_idx(x_r), lev_t'(0)};
      end
      S_DIST_RD: begin
        info_raddr = to_idx(x_r);
        alu_req.a  = alu_word_t'(la_r);
        alu_req.b  = alu_word_t'(lb_r);
      end
      S_DIST_SUB: begin
        alu_req.op = ALU_SUB;
        alu_req.a  = alu_word_t'(sum_r);
        alu_req.b  = {info_q.level, 1'b0};
      end
      default: begin
      end
    endcase
  end

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_CLEAR;
      clr_cnt  <= '0;
      out_full <= 1'b0;
    end else begin
      // output register
      if (out_load) begin
        out_full <= 1'b1;
        out_node <= res_node;
        out_ok   <= res_ok;
        out_dist <= res_dist;
      end else if (rsp.ready) begin
        out_full <= 1'b0;
      end

      case (state)
        S_CLEAR: begin
          clr_cnt <= clr_cnt + idx_t'(1);
          if (clr_cnt == idx_t'(NODES - 1)) begin
            state <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (req.valid) begin
            mode_r   <= mode_t'(req.mode);
            a_r      <= req.node_a;
            b_r      <= req.node_b;
            hasp_r   <= req.has_parent;
            k_r      <= kcnt_t'(req.steps);
            res_ok   <= 1'b0;
            res_node <= '0;
            res_dist <= '0;
            state    <= S_RD_A;
          end
        end
        S_RD_A: begin
          state <= S_CHK_A;
        end
        S_CHK_A: begin
          case (mode_r)
            MODE_ADD: begin
              if (!in_range(a_r) || info_q.loaded) begin
                state <= S_DONE;
              end else if (hasp_r) begin
                state <= S_CHK_B;
              end else begin
                cur_r <= '0;
                la_r  <= '0;
                state <= S_ADD_W0;
              end
            end
            MODE_KTH: begin
              if (!a_ok || alu_rsp.borrow) begin
                state <= S_DONE;
              end else begin
                x_r   <= a_r;
                j_r   <= '0;
                state <= S_CLIMB;
              end
            end
            default: begin
              if (!a_ok) begin
                state <= S_DONE;
              end else begin
                la_r  <= info_q.level;
                state <= S_CHK_B;
              end
            end
          endcase
        end
        S_CHK_B: begin
          if (mode_r == MODE_ADD) begin
            if (!b_ok || alu_rsp.borrow) begin
              state <= S_DONE;
            end else begin
              lb_r  <= info_q.level;
              state <= S_ADD_LV;
            end
          end else if (!b_ok) begin
            state <= S_DONE;
          end else begin
            lb_r  <= info_q.level;
            state <= S_ORDER;
          end
        end
        // add: fill the new node's row level by level
        S_ADD_LV: begin
          la_r     <= alu_rsp.res[NODE_W-1:0];
          cur_r.ok <= 1'b1;
          cur_r.id <= b_r;
          state    <= S_ADD_W0;
        end
        S_ADD_W0: begin
          j_r <= lev_t'(1);
          if (LEVELS == 1) begin
            state <= S_ADD_INFO;
          end else begin
            state <= S_ADD_RD;
          end
        end
        S_ADD_RD: begin
          if (cur_r.ok) begin
            state <= S_ADD_WR;
          end else if (j_r == LAST_LEV) begin
            state <= S_ADD_INFO;
          end else begin
            j_r <= j_r + lev_t'(1);
          end
        end
        S_ADD_WR: begin
          cur_r <= anc_q;
          if (j_r == LAST_LEV) begin
            state <= S_ADD_INFO;
          end else begin
            j_r   <= j_r + lev_t'(1);
            state <= S_ADD_RD;
          end
        end
        S_ADD_INFO: begin
          res_ok   <= 1'b1;
          res_node <= a_r;
          state    <= S_DONE;
        end
        // bring the deeper node up to the shallower depth
        S_ORDER: begin
          if (alu_rsp.borrow) begin
            state <= S_ORDER2;
          end else begin
            x_r   <= a_r;
            y_r   <= b_r;
            k_r   <= kcnt_t'(alu_rsp.res);
            j_r   <= '0;
            state <= S_CLIMB;
          end
        end
        S_ORDER2: begin
          x_r   <= b_r;
          y_r   <= a_r;
          k_r   <= kcnt_t'(alu_rsp.res);
          j_r   <= '0;
          state <= S_CLIMB;
        end
        // climb one set bit of k per table read
        S_CLIMB: begin
          if (k_r[0]) begin
            state <= S_CLIMB_WT;
          end else begin
            k_r <= k_r >> 1;
            if (j_r == LAST_LEV) begin
              state <= S_CLIMB_END;
            end else begin
              j_r <= j_r + lev_t'(1);
            end
          end
        end
        S_CLIMB_WT: begin
          if (!anc_q.ok) begin
            state <= S_DONE;
          end else begin
            x_r <= anc_q.id;
            k_r <= k_r >> 1;
            if (j_r == LAST_LEV) begin
              state <= S_CLIMB_END;
            end else begin
              j_r   <= j_r + lev_t'(1);
              state <= S_CLIMB;
            end
          end
        end
        S_CLIMB_END: begin
          if (k_r != '0) begin
            state <= S_DONE;
          end else if (mode_r == MODE_KTH) begin
            res_ok   <= 1'b1;
            res_node <= x_r;
            state    <= S_DONE;
          end else begin
            state <= S_CMP;
          end
        end
        S_CMP: begin
          if (x_r == y_r) begin
            if (mode_r == MODE_DIST) begin
              state <= S_DIST_RD;
            end else begin
              res_ok   <= 1'b1;
              res_node <= x_r;
              state    <= S_DONE;
            end
          end else begin
            j_r   <= LAST_LEV;
            state <= S_LCA_RA;
          end
        end
        // lift both nodes while their ancestors differ, top level first
        S_LCA_RA: begin
          state <= S_LCA_RB;
        end
        S_LCA_RB: begin
          ea_r  <= anc_q;
          state <= S_LCA_UP;
        end
        S_LCA_UP: begin
          if (ea_r != anc_q && ea_r.ok && anc_q.ok) begin
            x_r <= ea_r.id;
            y_r <= anc_q.id;
          end
          if (j_r == '0) begin
            state <= S_LCA_PR;
          end else begin
            j_r   <= j_r - lev_t'(1);
            state <= S_LCA_RA;
          end
        end
        S_LCA_PR: begin
          state <= S_LCA_FIN;
        end
        S_LCA_FIN: begin
          if (!anc_q.ok) begin
            state <= S_DONE;
          end else if (mode_r == MODE_DIST) begin
            x_r   <= anc_q.id;
            state <= S_DIST_RD;
          end else begin
            res_ok   <= 1'b1;
            res_node <= anc_q.id;
            state    <= S_DONE;
          end
        end
        // distance: depth a plus depth b minus twice the common depth
        S_DIST_RD: begin
          sum_r <= alu_rsp.res;
          state <= S_DIST_SUB;
        end
        S_DIST_SUB: begin
          res_ok   <= 1'b1;
          res_node <= x_r;
          res_dist <= alu_rsp.res;
          state    <= S_DONE;
        end
        S_DONE: begin
          if (out_load) begin
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // checks
  `BLA_ASSERT_NR(a_clear_after_reset, clk, rst |=> !req.ready, "item taken during clearing pass")
  `BLA_ASSERT(a_one_item, clk, rst, req.valid && req.ready |=> !req.ready, "second item taken while busy")
  `BLA_ASSERT(a_fail_zero, clk, rst, rsp.valid && !rsp.answer_valid |-> rsp.answer_node == '0 && rsp.edge_count == '0, "failed item has nonzero fields")
  `BLA_ASSERT(a_info_write, clk, rst, info_we |-> state == S_CLEAR || state == S_ADD_INFO, "node record written outside clear or add")

endmodule

### rtl/core/bla_alu.sv
// ----------------------------------------------------------------------------
// bla_alu
// Shared add/subtract unit; borrow doubles as the less-than compare.
// ----------------------------------------------------------------------------
module bla_alu import bla_pkg::*; (
  input  alu_req_t req,
  output alu_rsp_t rsp
);

  logic [ALU_W:0] wide;

  // add or subtract one bit wider; the extra bit gives the borrow
  always_comb begin
    case (req.op)
      ALU_SUB: wide = {1'b0, req.a} - {1'b0, req.b};
      ALU_ADD: wide = {1'b0, req.a} + {1'b0, req.b};
      default: wide = '0;
    endcase
    rsp.res    = wide[ALU_W-1:0];
    rsp.borrow = (req.op == ALU_SUB) ? wide[ALU_W] : 1'b0;
  end

endmodule
